>>> design/psd_pkg.sv
// Shared constants for the point-to-segment distance pipeline.
package psd_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned TFracBitsDef  = 16;
  localparam int unsigned OutWidth      = 17;

endpackage

>>> design/point_segment_distance_top.sv
// Top level of the point-to-segment distance pipeline.
//
// Input channel in_valid_i/in_ready_o carries one segment (start, end) and
// one query point, all signed Q12.4. Output channel out_valid_o/out_ready_i
// carries min_distance_o, the floor of the point-to-segment distance in Q.4.
// One result follows every input transfer, in order.
//
// Throughput: one transfer per cycle while the output is not stalled; the
// divider gives one quotient bit per stage and the square root one root
// bit per stage.
//
// Reset clears all stage valid bits; no result is pending after reset.
// The pipeline advances as a whole: while a result waits on the output and
// out_ready_i is low, every stage holds and in_ready_o is low. An empty
// output slot lets the pipeline advance and take new transfers.
module point_segment_distance_top import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned T_FRAC_BITS = TFracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [OutWidth-1:0]          min_distance_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned T  = T_FRAC_BITS;
  localparam int unsigned SW = 2 * CW + 2 + 2 * (CW + 1);
  localparam int unsigned R  = CW + 2;

  logic en;

  logic          f_valid, f_zero, f_one, f_dxn, f_dyn;
  logic [2*CW:0] f_len2, f_num;
  logic [CW-1:0] f_dxm, f_dym;
  logic signed [CW:0] f_rx, f_ry;

  logic          d_valid;
  logic [T:0]    d_t;
  logic [SW-1:0] d_side;

  logic            b_valid;
  logic [2*CW+2:0] b_sq;

  logic          s_valid;
  logic [R-1:0]  s_root;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  psd_front #(.CW(CW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .sx_i    (seg_start_x_i),
    .sy_i    (seg_start_y_i),
    .ex_i    (seg_end_x_i),
    .ey_i    (seg_end_y_i),
    .px_i    (point_x_i),
    .py_i    (point_y_i),
    .valid_o (f_valid),
    .len2_o  (f_len2),
    .num_o   (f_num),
    .zero_o  (f_zero),
    .one_o   (f_one),
    .dxm_o   (f_dxm),
    .dym_o   (f_dym),
    .dxn_o   (f_dxn),
    .dyn_o   (f_dyn),
    .rx_o    (f_rx),
    .ry_o    (f_ry)
  );

  psd_divider #(.CW(CW), .T(T), .SW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .len2_i  (f_len2),
    .num_i   (f_num),
    .zero_i  (f_zero),
    .one_i   (f_one),
    .side_i  ({f_dxm, f_dym, f_dxn, f_dyn, f_rx, f_ry}),
    .valid_o (d_valid),
    .t_o     (d_t),
    .side_o  (d_side)
  );

  psd_back #(.CW(CW), .T(T)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .t_i     (d_t),
    .dxm_i   (d_side[SW-1 -: CW]),
    .dym_i   (d_side[SW-CW-1 -: CW]),
    .dxn_i   (d_side[2*CW+3]),
    .dyn_i   (d_side[2*CW+2]),
    .rx_i    ($signed(d_side[2*CW+1 -: CW+1])),
    .ry_i    ($signed(d_side[CW:0])),
    .valid_o (b_valid),
    .sq_o    (b_sq)
  );

  psd_sqrt #(.CW(CW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid),
    .sq_i    (b_sq),
    .valid_o (s_valid),
    .root_o  (s_root)
  );

  assign out_valid_o = s_valid;

  if (R >= OutWidth) begin : g_out_trunc
    assign min_distance_o = s_root[OutWidth-1:0];
  end else begin : g_out_ext
    assign min_distance_o = OutWidth'(s_root);
  end

  a_t_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid |-> d_t <= {1'b1, {T{1'b0}}})
    else $error("projection parameter above one");

  a_t_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(d_t) && $stable(d_valid))
    else $error("divider output moved during stall");

  a_sq_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(b_sq) && $stable(b_valid))
    else $error("squared distance moved during stall");

endmodule

>>> design/psd_front.sv
// Front stages: differences, magnitudes, products, sums and projection flags.
module psd_front import psd_pkg::*; #(
  parameter int unsigned CW = CoordWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [CW-1:0] sx_i,
  input  logic signed [CW-1:0] sy_i,
  input  logic signed [CW-1:0] ex_i,
  input  logic signed [CW-1:0] ey_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  output logic                valid_o,
  output logic [2*CW:0]       len2_o,
  output logic [2*CW:0]       num_o,
  output logic                zero_o,
  output logic                one_o,
  output logic [CW-1:0]       dxm_o,
  output logic [CW-1:0]       dym_o,
  output logic                dxn_o,
  output logic                dyn_o,
  output logic signed [CW:0]  rx_o,
  output logic signed [CW:0]  ry_o
);

  localparam int unsigned W1 = CW + 1;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned LW = 2 * CW + 1;

  logic [3:0] v_q;

  // stage 1: differences
  logic signed [CW:0] dx1_q, dy1_q, rx1_q, ry1_q;
  // stage 2: magnitudes and signs
  logic [CW-1:0] dxm2_q, dym2_q, rxm2_q, rym2_q;
  logic          dxn2_q, dyn2_q, sgx2_q, sgy2_q;
  logic signed [CW:0] rx2_q, ry2_q;
  // stage 3: products
  logic [PW-1:0] pdx3_q, pdy3_q, prx3_q, pry3_q;
  logic          dxn3_q, dyn3_q, sgx3_q, sgy3_q;
  logic [CW-1:0] dxm3_q, dym3_q;
  logic signed [CW:0] rx3_q, ry3_q;
  // stage 4: sums
  logic [LW-1:0] len24_q, pos4_q, neg4_q;
  logic          dxn4_q, dyn4_q;
  logic [CW-1:0] dxm4_q, dym4_q;
  logic signed [CW:0] rx4_q, ry4_q;
  // stage 5: outputs
  logic          v5_q;

  logic [W1-1:0] dxa, dya, rxa, rya;
  logic [LW-1:0] pos_d, neg_d, nsub;

  assign dxa = dx1_q[CW] ? W1'(-dx1_q) : W1'(dx1_q);
  assign dya = dy1_q[CW] ? W1'(-dy1_q) : W1'(dy1_q);
  assign rxa = rx1_q[CW] ? W1'(-rx1_q) : W1'(rx1_q);
  assign rya = ry1_q[CW] ? W1'(-ry1_q) : W1'(ry1_q);

  assign pos_d = (sgx3_q ? LW'(0) : LW'(prx3_q)) + (sgy3_q ? LW'(0) : LW'(pry3_q));
  assign neg_d = (sgx3_q ? LW'(prx3_q) : LW'(0)) + (sgy3_q ? LW'(pry3_q) : LW'(0));
  assign nsub  = pos4_q - neg4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[2:0], valid_i};
      v5_q <= v_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q  <= {ex_i[CW-1], ex_i} - {sx_i[CW-1], sx_i};
      dy1_q  <= {ey_i[CW-1], ey_i} - {sy_i[CW-1], sy_i};
      rx1_q  <= {px_i[CW-1], px_i} - {sx_i[CW-1], sx_i};
      ry1_q  <= {py_i[CW-1], py_i} - {sy_i[CW-1], sy_i};

      dxm2_q <= dxa[CW-1:0];
      dym2_q <= dya[CW-1:0];
      rxm2_q <= rxa[CW-1:0];
      rym2_q <= rya[CW-1:0];
      dxn2_q <= dx1_q[CW];
      dyn2_q <= dy1_q[CW];
      sgx2_q <= rx1_q[CW] ^ dx1_q[CW];
      sgy2_q <= ry1_q[CW] ^ dy1_q[CW];
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;

      pdx3_q <= dxm2_q * dxm2_q;
      pdy3_q <= dym2_q * dym2_q;
      prx3_q <= rxm2_q * dxm2_q;
      pry3_q <= rym2_q * dym2_q;
      dxn3_q <= dxn2_q;
      dyn3_q <= dyn2_q;
      sgx3_q <= sgx2_q;
      sgy3_q <= sgy2_q;
      dxm3_q <= dxm2_q;
      dym3_q <= dym2_q;
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;

      len24_q <= LW'(pdx3_q) + LW'(pdy3_q);
      pos4_q  <= pos_d;
      neg4_q  <= neg_d;
      dxn4_q  <= dxn3_q;
      dyn4_q  <= dyn3_q;
      dxm4_q  <= dxm3_q;
      dym4_q  <= dym3_q;
      rx4_q   <= rx3_q;
      ry4_q   <= ry3_q;

      len2_o <= len24_q;
      num_o  <= nsub;
      zero_o <= (len24_q == '0) || (pos4_q <= neg4_q);
      one_o  <= (len24_q != '0) && (pos4_q > neg4_q) && (nsub >= len24_q);
      dxm_o  <= dxm4_q;
      dym_o  <= dym4_q;
      dxn_o  <= dxn4_q;
      dyn_o  <= dyn4_q;
      rx_o   <= rx4_q;
      ry_o   <= ry4_q;
    end
  end

  assign valid_o = v5_q;

endmodule

>>> design/psd_divider.sv
// Pipelined restoring divider, one quotient bit per stage, clamps t to [0, 1].
module psd_divider import psd_pkg::*; #(
  parameter int unsigned CW = CoordWidthDef,
  parameter int unsigned T  = TFracBitsDef,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [2*CW:0] len2_i,
  input  logic [2*CW:0] num_i,
  input  logic          zero_i,
  input  logic          one_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [T:0]    t_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned LW = 2 * CW + 1;

  logic [LW-1:0] rem_q  [T+1];
  logic [LW-1:0] len2_q [T+1];
  logic [T-1:0]  quo_q  [T+1];
  logic          zero_q [T+1];
  logic          one_q  [T+1];
  logic [SW-1:0] side_q [T+1];
  logic [T:0]    v_q;

  always_comb begin
    rem_q[0]  = num_i;
    len2_q[0] = len2_i;
    quo_q[0]  = '0;
    zero_q[0] = zero_i;
    one_q[0]  = one_i;
    side_q[0] = side_i;
    v_q[0]    = valid_i;
  end

  for (genvar k = 0; k < T; k++) begin : g_step
    logic [LW:0] rem2;
    logic        ge;
    logic [LW:0] rem_sub;

    assign rem2    = {rem_q[k], 1'b0};
    assign ge      = rem2 >= {1'b0, len2_q[k]};
    assign rem_sub = rem2 - {1'b0, len2_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_sub[LW-1:0] : rem2[LW-1:0];
        quo_q[k+1]  <= {quo_q[k][T-2:0], ge};
        len2_q[k+1] <= len2_q[k];
        zero_q[k+1] <= zero_q[k];
        one_q[k+1]  <= one_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[T];
  assign side_o  = side_q[T];
  assign t_o     = zero_q[T] ? '0 :
                   one_q[T]  ? {1'b1, {T{1'b0}}} : {1'b0, quo_q[T]};

endmodule

>>> design/psd_back.sv
// Back stages: projection offsets, error vector and squared distance.
module psd_back import psd_pkg::*; #(
  parameter int unsigned CW = CoordWidthDef,
  parameter int unsigned T  = TFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [T:0]         t_i,
  input  logic [CW-1:0]      dxm_i,
  input  logic [CW-1:0]      dym_i,
  input  logic               dxn_i,
  input  logic               dyn_i,
  input  logic signed [CW:0] rx_i,
  input  logic signed [CW:0] ry_i,
  output logic               valid_o,
  output logic [2*CW+2:0]    sq_o
);

  localparam int unsigned PW = CW + T + 1;
  localparam int unsigned RW = PW + 1;
  localparam int unsigned EW = CW + 2;
  localparam int unsigned MW = CW + 1;
  localparam int unsigned QW = 2 * CW + 2;
  localparam int unsigned SQW = 2 * CW + 3;

  logic [5:0] v_q;

  logic [PW-1:0] ox1_q, oy1_q;
  logic          dxn1_q, dyn1_q, dxn2_q, dyn2_q;
  logic signed [CW:0] rx1_q, ry1_q, rx2_q, ry2_q;
  logic [MW-1:0] om2x_q, om2y_q;
  logic signed [EW-1:0] ex3_q, ey3_q;
  logic [MW-1:0] exm4_q, eym4_q;
  logic [QW-1:0] sqx5_q, sqy5_q;

  logic signed [EW-1:0] rxe, rye, omxe, omye;
  logic [EW-1:0] exa, eya;

  logic [RW-1:0] halfc;
  assign halfc = RW'(1) << (T - 1);

  assign rxe  = EW'(rx2_q);
  assign rye  = EW'(ry2_q);
  assign omxe = EW'($signed({1'b0, om2x_q}));
  assign omye = EW'($signed({1'b0, om2y_q}));
  assign exa  = ex3_q[EW-1] ? EW'(-ex3_q) : EW'(ex3_q);
  assign eya  = ey3_q[EW-1] ? EW'(-ey3_q) : EW'(ey3_q);

  logic [RW-1:0] sumx, sumy;
  assign sumx = RW'(ox1_q) + halfc;
  assign sumy = RW'(oy1_q) + halfc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ox1_q  <= PW'(dxm_i * t_i);
      oy1_q  <= PW'(dym_i * t_i);
      dxn1_q <= dxn_i;
      dyn1_q <= dyn_i;
      rx1_q  <= rx_i;
      ry1_q  <= ry_i;

      om2x_q <= MW'(sumx >> T);
      om2y_q <= MW'(sumy >> T);
      dxn2_q <= dxn1_q;
      dyn2_q <= dyn1_q;
      rx2_q  <= rx1_q;
      ry2_q  <= ry1_q;

      ex3_q  <= dxn2_q ? rxe + omxe : rxe - omxe;
      ey3_q  <= dyn2_q ? rye + omye : rye - omye;

      exm4_q <= exa[MW-1:0];
      eym4_q <= eya[MW-1:0];

      sqx5_q <= exm4_q * exm4_q;
      sqy5_q <= eym4_q * eym4_q;

      sq_o   <= SQW'(sqx5_q) + SQW'(sqy5_q);
    end
  end

  assign valid_o = v_q[5];

endmodule

>>> design/psd_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
module psd_sqrt import psd_pkg::*; #(
  parameter int unsigned CW = CoordWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*CW+2:0] sq_i,
  output logic            valid_o,
  output logic [CW+1:0]   root_o
);

  localparam int unsigned R  = CW + 2;
  localparam int unsigned NW = 2 * R;

  logic [NW-1:0] num_q  [R+1];
  logic [R+1:0]  rem_q  [R+1];
  logic [R-1:0]  root_q [R+1];
  logic [R:0]    v_q;

  always_comb begin
    num_q[0]  = NW'(sq_i);
    rem_q[0]  = '0;
    root_q[0] = '0;
    v_q[0]    = valid_i;
  end

  for (genvar k = 0; k < R; k++) begin : g_step
    logic [R+1:0] rem_sh, trial, rem_sub;
    logic         ge;

    assign rem_sh  = {rem_q[k][R-1:0], num_q[k][NW-1:NW-2]};
    assign trial   = {root_q[k], 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_sub : rem_sh;
        root_q[k+1] <= {root_q[k][R-2:0], ge};
        num_q[k+1]  <= {num_q[k][NW-3:0], 2'b00};
      end
    end
  end

  assign valid_o = v_q[R];
  assign root_o  = root_q[R];

endmodule

>>> tb/sv/psd_checker.sv
// Checker for the point-to-segment distance block: predicts and compares results.
module psd_checker import psd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidthDef,
  parameter int unsigned T_FRAC_BITS = TFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] seg_end_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [OutWidth-1:0]           min_distance_i,
  output int                            pending_o,
  output int                            errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [OutWidth-1:0] dist_q[$];

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint proj_offset(longint d, longint unsigned t);
    longint o;
    o = longint'((abs64(d) * t + (64'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS);
    return d < 0 ? -o : o;
  endfunction

  function automatic logic [OutWidth-1:0] seg_distance(longint sx, longint sy, longint ex,
                                                       longint ey, longint px, longint py);
    longint dx, dy, rx, ry, erx, ery;
    longint unsigned len2, pos, neg, t, ax, ay, n;
    dx = ex - sx; dy = ey - sy;
    rx = px - sx; ry = py - sy;
    len2 = abs64(dx) * abs64(dx) + abs64(dy) * abs64(dy);
    ax = abs64(rx) * abs64(dx);
    ay = abs64(ry) * abs64(dy);
    pos = 0; neg = 0; t = 0;
    if ((rx < 0) != (dx < 0)) neg += ax; else pos += ax;
    if ((ry < 0) != (dy < 0)) neg += ay; else pos += ay;
    if (len2 != 0 && pos > neg) begin
      n = pos - neg;
      if (n >= len2) t = 64'd1 << T_FRAC_BITS;
      else t = (n << T_FRAC_BITS) / len2;
    end
    erx = rx - proj_offset(dx, t);
    ery = ry - proj_offset(dy, t);
    return OutWidth'(floor_sqrt(abs64(erx) * abs64(erx) + abs64(ery) * abs64(ery)));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        dist_q.push_back(seg_distance(seg_start_x_i, seg_start_y_i, seg_end_x_i,
                                      seg_end_y_i, point_x_i, point_y_i));
      if (out_valid_i && out_ready_i) begin
        if (dist_q.size() == 0) begin
          $error("unexpected transfer: min_distance actual %0d", min_distance_i);
          errors_o <= errors_o + 1;
        end else begin
          if (dist_q[0] !== min_distance_i) begin
            $error("min_distance expected %0d actual %0d", dist_q[0], min_distance_i);
            errors_o <= errors_o + 1;
          end
          void'(dist_q.pop_front());
        end
      end
    end
  end

  assign pending_o = dist_q.size();
endmodule

>>> tb/sv/tb_point_segment_distance_top.sv
// Testbench top for the point-to-segment distance block: stimulus and verdict.
module tb_point_segment_distance_top import psd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = CoordWidthDef;
  localparam int NumRandom = 306;
  localparam int Latency = 45;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] sx = '0, sy = '0, ex = '0, ey = '0, px = '0, py = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OutWidth-1:0] min_distance_o;
  int pending, errors, cycles;
  bit stim_done = 0;
  bit long_stall = 0;

  always #5 clk_i = ~clk_i;

  point_segment_distance_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .seg_start_x_i(sx), .seg_start_y_i(sy), .seg_end_x_i(ex), .seg_end_y_i(ey),
    .point_x_i(px), .point_y_i(py),
    .out_valid_o, .out_ready_i, .min_distance_o
  );

  psd_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .seg_start_x_i(sx), .seg_start_y_i(sy), .seg_end_x_i(ex), .seg_end_y_i(ey),
    .point_x_i(px), .point_y_i(py),
    .out_valid_i(out_valid_o), .out_ready_i, .min_distance_i(min_distance_o),
    .pending_o(pending), .errors_o(errors)
  );

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000 + CW'($urandom_range(0, 3));
      1: return 16'h7fff - CW'($urandom_range(0, 3));
      2: return CW'($urandom_range(0, 64)) - 16'd32;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send(logic [CW-1:0] a, b, c, d, e, f);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    repeat (gap) @(posedge clk_i);
    sx <= a; sy <= b; ex <= c; ey <= d; px <= e; py <= f;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_burst(logic [CW-1:0] a, b, c, d, e, f);
    sx <= a; sy <= b; ex <= c; ey <= d; px <= e; py <= f;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random();
    logic [CW-1:0] a, b, c, d;
    a = rand_coord(); b = rand_coord();
    case ($urandom_range(0, 7))
      0: begin c = a; d = b; end
      1: begin c = a + CW'($urandom_range(0, 4)); d = b; end
      default: begin c = rand_coord(); d = rand_coord(); end
    endcase
    send(a, b, c, d, rand_coord(), rand_coord());
  endtask

  // receiver: random stalls, one long hold-off when requested
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_stall = 0;
      end
      wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
      if (wait_n != 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(0, 0, 0, 0, 0, 0);
    send(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send(0, 0, 16, 0, -16, 16);
    send(0, 0, 16, 0, 48, 16);
    send(0, 0, 16, 0, 8, 16);
    send(0, 0, 16, 16, 16, 0);
    send(16'h7fff, 0, 16'h8000, 0, 0, 16'h7fff);
    send(0, 16'h7fff, 0, 16'h8000, 16'h8000, 16'h8000);
    send(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'haaaa, 16'h5555);
    send(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
    send(0, 0, 1, 0, 16'h7fff, 16'h7fff);
    wait (pending == 0);
    @(posedge clk_i);
    long_stall = 1;
    for (int i = 0; i < 80; i++)
      send_burst(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord());
    in_valid_i <= 1'b0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) begin
        wait (pending == 0);
        @(posedge clk_i);
      end
      send_random();
    end
    wait (pending == 0);
    repeat (Latency + 10) @(posedge clk_i);
    stim_done = 1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (stim_done) begin
      if (errors == 0 && pending == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
    end else if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial cycles = 0;
endmodule
